/* hw/rtl/bbs_pkg.sv */
// ----------------------------------------------------------------------------
// Bounding box stack package
// Shared types, constants and saturation helper for the bounding box stack.
// ----------------------------------------------------------------------------
package bbs_pkg;

   // Number of boxes the stack holds.
   localparam int STACK_DEPTH = 16;
   // Width of the box counter, wide enough to hold the depth itself.
   localparam int COUNT_WIDTH = $clog2(STACK_DEPTH + 1);

   localparam logic [31:0] EMPTY_LOW  = 32'h7FFF_FFFF;
   localparam logic [31:0] EMPTY_HIGH = 32'h8000_0000;

   typedef enum logic [2:0] {
      FUNC_CLEAR    = 3'd0,
      FUNC_PUSH     = 3'd1,
      FUNC_POP      = 3'd2,
      FUNC_GROW     = 3'd3,
      FUNC_SET_CS   = 3'd4,
      FUNC_SET_LH   = 3'd5,
      FUNC_READ_LH  = 3'd6,
      FUNC_READ_CS  = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   // One coordinate triple, index 0 is x, 1 is y, 2 is z.
   typedef logic [2:0][31:0] coord_type;

   typedef struct packed {
      coord_type lo;
      coord_type hi;
   } box_type;

   // Shift commands for the cells below the top of the stack.
   typedef struct packed {
      logic take_above;   // push: copy the box of the cell above
      logic take_below;   // pop: copy the box of the cell below
   } cell_ctrl_type;

   // Saturates a 33 bit signed value to the 32 bit signed range.
   function automatic logic [31:0] sat33(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? EMPTY_HIGH : EMPTY_LOW;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* hw/rtl/bbs_if.sv */
// ----------------------------------------------------------------------------
// Bounding box stack channels
// Valid/ready channels carrying requests to and responses from the stack.
// ----------------------------------------------------------------------------
interface bbs_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         func;
   logic               merge_on_pop;
   logic signed [31:0] a_x;
   logic signed [31:0] a_y;
   logic signed [31:0] a_z;
   logic signed [31:0] b_x;
   logic signed [31:0] b_y;
   logic signed [31:0] b_z;
   logic [30:0]        radius;

   modport source (output valid, func, merge_on_pop, a_x, a_y, a_z, b_x, b_y, b_z,
                   radius, input ready);
   modport sink   (input valid, func, merge_on_pop, a_x, a_y, a_z, b_x, b_y, b_z,
                   radius, output ready);
endinterface

interface bbs_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         stack_depth;
   logic [1:0]         error;
   logic signed [31:0] out_a_x;
   logic signed [31:0] out_a_y;
   logic signed [31:0] out_a_z;
   logic signed [31:0] out_b_x;
   logic signed [31:0] out_b_y;
   logic signed [31:0] out_b_z;

   modport source (output valid, stack_depth, error, out_a_x, out_a_y, out_a_z,
                   out_b_x, out_b_y, out_b_z, input ready);
   modport sink   (input valid, stack_depth, error, out_a_x, out_a_y, out_a_z,
                   out_b_x, out_b_y, out_b_z, output ready);
endinterface

/* hw/rtl/bbs_cell.sv */
// ----------------------------------------------------------------------------
// Bounding box stack cell
// Holds one box below the top; shifts down on push and up on pop.
// ----------------------------------------------------------------------------
module bbs_cell (
   input  logic                   clock,
   input  bbs_pkg::cell_ctrl_type ctrl,
   input  bbs_pkg::box_type       from_above,
   input  bbs_pkg::box_type       from_below,
   output bbs_pkg::box_type       box_out
);

   bbs_pkg::box_type box_ff;
   bbs_pkg::box_type box_in;

   always_comb begin
      priority if (ctrl.take_above) begin
         box_in = from_above;
      end else if (ctrl.take_below) begin
         box_in = from_below;
      end else begin
         box_in = box_ff;
      end
   end

   // Contents are undefined until a push writes them.
   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box_out = box_ff;

endmodule

/* hw/rtl/bbs_head.sv */
// ----------------------------------------------------------------------------
// Bounding box stack head cell
// Holds the top box and carries out every operation that acts on it.
// ----------------------------------------------------------------------------
module bbs_head (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  bbs_pkg::func_type  func,
   input  logic               merge_on_pop,
   input  logic               pop_ok,
   input  bbs_pkg::coord_type a,
   input  bbs_pkg::coord_type b,
   input  logic [30:0]        radius,
   input  bbs_pkg::box_type   from_below,
   output bbs_pkg::box_type   top_out,
   output bbs_pkg::coord_type res_a,
   output bbs_pkg::coord_type res_b
);

   bbs_pkg::box_type top_ff;
   bbs_pkg::box_type top_in;

   bbs_pkg::box_type   empty_box;
   bbs_pkg::box_type   grow_box;
   bbs_pkg::box_type   cs_box;
   bbs_pkg::box_type   merge_box;
   bbs_pkg::coord_type centre;
   bbs_pkg::coord_type size;

   always_comb begin
      logic [32:0] grow_lo;
      logic [32:0] grow_hi;
      logic [31:0] lo_sat;
      logic [31:0] hi_sat;
      logic [33:0] twice;
      logic [33:0] b_ext;
      logic [33:0] cs_lo;
      logic [33:0] cs_hi;
      logic [32:0] sum;
      logic [32:0] diff;
      for (int k = 0; k < 3; k++) begin
         empty_box.lo[k] = bbs_pkg::EMPTY_LOW;
         empty_box.hi[k] = bbs_pkg::EMPTY_HIGH;

         // Grow by a sphere: saturated point minus and plus radius.
         grow_lo = {a[k][31], a[k]} - {2'b00, radius};
         grow_hi = {a[k][31], a[k]} + {2'b00, radius};
         lo_sat  = bbs_pkg::sat33(grow_lo);
         hi_sat  = bbs_pkg::sat33(grow_hi);
         grow_box.lo[k] = ($signed(lo_sat) < $signed(top_ff.lo[k])) ? lo_sat : top_ff.lo[k];
         grow_box.hi[k] = ($signed(hi_sat) > $signed(top_ff.hi[k])) ? hi_sat : top_ff.hi[k];

         // Centre and size: dropping the lowest bit of 2c -/+ s is the floor halving.
         twice = {a[k][31], a[k], 1'b0};
         b_ext = {{2{b[k][31]}}, b[k]};
         cs_lo = twice - b_ext;
         cs_hi = twice + b_ext;
         cs_box.lo[k] = bbs_pkg::sat33(cs_lo[33:1]);
         cs_box.hi[k] = bbs_pkg::sat33(cs_hi[33:1]);

         // Merge of the popped box into the one below.
         merge_box.lo[k] = ($signed(from_below.lo[k]) > $signed(top_ff.lo[k])) ?
                           top_ff.lo[k] : from_below.lo[k];
         merge_box.hi[k] = ($signed(from_below.hi[k]) < $signed(top_ff.hi[k])) ?
                           top_ff.hi[k] : from_below.hi[k];

         // Read back as centre and size.
         sum       = {top_ff.lo[k][31], top_ff.lo[k]} + {top_ff.hi[k][31], top_ff.hi[k]};
         diff      = {top_ff.hi[k][31], top_ff.hi[k]} - {top_ff.lo[k][31], top_ff.lo[k]};
         centre[k] = sum[32:1];
         size[k]   = bbs_pkg::sat33(diff);
      end
   end

   always_comb begin
      top_in = top_ff;
      unique case (func)
         bbs_pkg::FUNC_CLEAR: begin
            top_in = empty_box;
         end
         bbs_pkg::FUNC_PUSH: begin
            top_in = top_ff;
         end
         bbs_pkg::FUNC_POP: begin
            if (pop_ok) begin
               top_in = merge_on_pop ? merge_box : from_below;
            end
         end
         bbs_pkg::FUNC_GROW: begin
            top_in = grow_box;
         end
         bbs_pkg::FUNC_SET_CS: begin
            top_in = cs_box;
         end
         bbs_pkg::FUNC_SET_LH: begin
            top_in.lo = a;
            top_in.hi = b;
         end
         bbs_pkg::FUNC_READ_LH,
         bbs_pkg::FUNC_READ_CS: begin
            top_in = top_ff;
         end
         default: begin
            top_in = top_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= empty_box;
      end else if (accept) begin
         top_ff <= top_in;
      end
   end

   // A push leaves the top unchanged; only the cells below move.
   assign top_out = top_ff;
   assign res_a   = (func == bbs_pkg::FUNC_READ_CS) ? centre : top_in.lo;
   assign res_b   = (func == bbs_pkg::FUNC_READ_CS) ? size   : top_in.hi;

endmodule

/* hw/rtl/bounding_box_stack.sv */
// ----------------------------------------------------------------------------
// Bounding box stack
// Stack of 3D axis-aligned boxes in Q16.16, built as a row of box cells.
// ----------------------------------------------------------------------------
// Every operation completes in the head cell; its response is registered and shows in the
// cycle after acceptance. Throughput: one request per cycle while responses are taken.
// A new request is taken while the previous response is still being taken.
// Reset: synchronous, active high; one empty box on the stack, no response pending.
// Cells below the top hold undefined data until a push fills them.
// ----------------------------------------------------------------------------
module bounding_box_stack (
   input logic       clock,
   input logic       reset,
   bbs_req_if.sink   req_chan,
   bbs_rsp_if.source rsp_chan
);

   // The top box always lives in the head cell; the cells below form a shift
   // line, so a push moves every box one cell down and a pop one cell up.
   // The depth counter decides whether a push or a pop is legal and gives the reported depth.

   logic                              accept;
   logic                              push_ok;
   logic                              pop_ok;
   logic                              full;
   logic                              at_one;
   bbs_pkg::func_type                 func;
   bbs_pkg::coord_type                a_in;
   bbs_pkg::coord_type                b_in;
   bbs_pkg::coord_type                res_a;
   bbs_pkg::coord_type                res_b;
   bbs_pkg::cell_ctrl_type            ctrl;
   bbs_pkg::box_type                  chain [0:bbs_pkg::STACK_DEPTH];

   logic [bbs_pkg::COUNT_WIDTH-1:0]   count_ff;
   logic [bbs_pkg::COUNT_WIDTH-1:0]   count_in;
   logic                              rsp_valid_ff;
   logic [4:0]                        depth_ff;
   bbs_pkg::err_type                  err_ff;
   bbs_pkg::err_type                  err_in;
   bbs_pkg::coord_type                out_a_ff;
   bbs_pkg::coord_type                out_b_ff;

   // A request is taken whenever the response register is free or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign func = bbs_pkg::func_type'(req_chan.func);
   assign a_in = {req_chan.a_z, req_chan.a_y, req_chan.a_x};
   assign b_in = {req_chan.b_z, req_chan.b_y, req_chan.b_x};

   assign full    = (count_ff == bbs_pkg::COUNT_WIDTH'(bbs_pkg::STACK_DEPTH));
   assign at_one  = (count_ff == bbs_pkg::COUNT_WIDTH'(1));
   assign push_ok = (func == bbs_pkg::FUNC_PUSH) && !full;
   assign pop_ok  = (func == bbs_pkg::FUNC_POP) && !at_one;

   assign ctrl.take_above = accept && push_ok;
   assign ctrl.take_below = accept && pop_ok;

   bbs_head u_head (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (func),
      .merge_on_pop (req_chan.merge_on_pop),
      .pop_ok       (pop_ok),
      .a            (a_in),
      .b            (b_in),
      .radius       (req_chan.radius),
      .from_below   (chain[1]),
      .top_out      (chain[0]),
      .res_a        (res_a),
      .res_b        (res_b)
   );

   // The last cell sees itself below, so a pop leaves it as it was.
   assign chain[bbs_pkg::STACK_DEPTH] = chain[bbs_pkg::STACK_DEPTH-1];

   for (genvar i = 1; i < bbs_pkg::STACK_DEPTH; i++) begin : g_cell
      bbs_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .from_above (chain[i-1]),
         .from_below (chain[i+1]),
         .box_out    (chain[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      err_in   = bbs_pkg::ERR_OK;
      priority if (func == bbs_pkg::FUNC_PUSH) begin
         if (full) begin
            err_in = bbs_pkg::ERR_FULL;
         end else begin
            count_in = count_ff + bbs_pkg::COUNT_WIDTH'(1);
         end
      end else if (func == bbs_pkg::FUNC_POP) begin
         if (at_one) begin
            err_in = bbs_pkg::ERR_EMPTY;
         end else begin
            count_in = count_ff - bbs_pkg::COUNT_WIDTH'(1);
         end
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= bbs_pkg::COUNT_WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response payload is loaded with each accepted request and needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         depth_ff <= 5'(count_in);
         err_ff   <= err_in;
         out_a_ff <= res_a;
         out_b_ff <= res_b;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.stack_depth = depth_ff;
   assign rsp_chan.error       = err_ff;
   assign rsp_chan.out_a_x     = out_a_ff[0];
   assign rsp_chan.out_a_y     = out_a_ff[1];
   assign rsp_chan.out_a_z     = out_a_ff[2];
   assign rsp_chan.out_b_x     = out_b_ff[0];
   assign rsp_chan.out_b_y     = out_b_ff[1];
   assign rsp_chan.out_b_z     = out_b_ff[2];

endmodule

/* bench/bounding_box_stack_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounding box stack testbench
// Drives requests into the box stack with random gaps and response stalls,
// mirrors the stack in a software tracker and checks every response field.
// ----------------------------------------------------------------------------
module bounding_box_stack_tb;

   // Timing of the run. The cycle limit is several times the slowest legal run:
   // about 1400 requests, each with the longest gap, the longest stall and the
   // registered response, plus the drains between blocks.
   localparam int HALF_PERIOD   = 2;
   localparam int RESET_CYCLES  = 8;
   localparam int MAX_IDLE      = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_BLOCKS = 27;
   localparam int BLOCK_SIZE    = 50;
   localparam int REPORT_LIMIT  = 10;

   // One request as the tracker sees it. The radius is held as a non-negative int.
   typedef struct {
      bbs_pkg::func_type func;
      logic              merge;
      int                a[3];
      int                b[3];
      int                radius;
   } box_request_type;

   // One response: the stack depth, the error code and the two coordinate triples.
   typedef struct {
      bbs_pkg::func_type  func;
      int                 serial;
      logic [4:0]         depth;
      logic [1:0]         error;
      logic signed [31:0] oa[3];
      logic signed [31:0] ob[3];
   } box_response_type;

   // The tracker keeps its own copy of the stack, works out the response to each
   // accepted request and compares responses in order as they arrive.
   class stack_tracker;
      int               lo_box[3][bbs_pkg::STACK_DEPTH];
      int               hi_box[3][bbs_pkg::STACK_DEPTH];
      int               box_count;
      int               request_count;
      int               mismatch_count;
      box_response_type expected_tops[$];

      function new();
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < bbs_pkg::STACK_DEPTH; i++) begin
               lo_box[k][i] = 0;
               hi_box[k][i] = 0;
            end
            lo_box[k][0] = bbs_pkg::EMPTY_LOW;
            hi_box[k][0] = bbs_pkg::EMPTY_HIGH;
         end
         box_count      = 1;
         request_count  = 0;
         mismatch_count = 0;
      endfunction

      function int clamp32(longint v);
         if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
         if (v < -longint'(64'sh8000_0000)) return 32'sh8000_0000;
         return int'(v);
      endfunction

      function void note_request(box_request_type rq);
         box_response_type rs;
         int     top;
         longint lo;
         longint hi;
         int     c;

         rs.func   = rq.func;
         rs.serial = request_count++;
         rs.error  = bbs_pkg::ERR_OK;
         top       = box_count - 1;
         case (rq.func)
            bbs_pkg::FUNC_CLEAR: begin
               for (int k = 0; k < 3; k++) begin
                  lo_box[k][top] = bbs_pkg::EMPTY_LOW;
                  hi_box[k][top] = bbs_pkg::EMPTY_HIGH;
               end
            end
            bbs_pkg::FUNC_PUSH: begin
               if (box_count >= bbs_pkg::STACK_DEPTH) begin
                  rs.error = bbs_pkg::ERR_FULL;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     lo_box[k][top + 1] = lo_box[k][top];
                     hi_box[k][top + 1] = hi_box[k][top];
                  end
                  box_count++;
               end
            end
            bbs_pkg::FUNC_POP: begin
               if (box_count <= 1) begin
                  rs.error = bbs_pkg::ERR_EMPTY;
               end else begin
                  // Merging widens the box below to cover the one taken off.
                  if (rq.merge) begin
                     for (int k = 0; k < 3; k++) begin
                        if (lo_box[k][top - 1] > lo_box[k][top])
                           lo_box[k][top - 1] = lo_box[k][top];
                        if (hi_box[k][top - 1] < hi_box[k][top])
                           hi_box[k][top - 1] = hi_box[k][top];
                     end
                  end
                  box_count--;
               end
            end
            bbs_pkg::FUNC_GROW: begin
               for (int k = 0; k < 3; k++) begin
                  c = clamp32(longint'(rq.a[k]) - longint'(rq.radius));
                  if (c < lo_box[k][top]) lo_box[k][top] = c;
                  c = clamp32(longint'(rq.a[k]) + longint'(rq.radius));
                  if (c > hi_box[k][top]) hi_box[k][top] = c;
               end
            end
            bbs_pkg::FUNC_SET_CS: begin
               // Halving by an arithmetic shift rounds towards minus infinity.
               for (int k = 0; k < 3; k++) begin
                  lo = 2 * longint'(rq.a[k]) - longint'(rq.b[k]);
                  hi = 2 * longint'(rq.a[k]) + longint'(rq.b[k]);
                  lo_box[k][top] = clamp32(lo >>> 1);
                  hi_box[k][top] = clamp32(hi >>> 1);
               end
            end
            bbs_pkg::FUNC_SET_LH: begin
               for (int k = 0; k < 3; k++) begin
                  lo_box[k][top] = rq.a[k];
                  hi_box[k][top] = rq.b[k];
               end
            end
            default: begin
            end
         endcase

         top = box_count - 1;
         for (int k = 0; k < 3; k++) begin
            lo = longint'(lo_box[k][top]);
            hi = longint'(hi_box[k][top]);
            if (rq.func == bbs_pkg::FUNC_READ_CS) begin
               rs.oa[k] = int'((lo + hi) >>> 1);
               rs.ob[k] = clamp32(hi - lo);
            end else begin
               rs.oa[k] = int'(lo);
               rs.ob[k] = int'(hi);
            end
         end
         rs.depth = box_count[4:0];
         expected_tops.push_back(rs);
      endfunction

      function void check_response(box_response_type got);
         box_response_type want;
         logic             bad;

         if (expected_tops.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Response with no request outstanding at %0t", $realtime);
            return;
         end
         want = expected_tops.pop_front();
         bad  = (got.depth !== want.depth) || (got.error !== want.error);
         for (int k = 0; k < 3; k++)
            bad = bad || (got.oa[k] !== want.oa[k]) || (got.ob[k] !== want.ob[k]);
         if (bad) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("Mismatch on request %0d (%s) at %0t", want.serial, want.func.name(),
                        $realtime);
               $display("  depth  expected %0d got %0d, error expected %0d got %0d",
                        want.depth, got.depth, want.error, got.error);
               $display("  a      expected %h %h %h got %h %h %h",
                        want.oa[0], want.oa[1], want.oa[2], got.oa[0], got.oa[1], got.oa[2]);
               $display("  b      expected %h %h %h got %h %h %h",
                        want.ob[0], want.ob[1], want.ob[2], got.ob[0], got.ob[1], got.ob[2]);
            end
         end
      endfunction

      function int pending();
         return expected_tops.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count;
   // When set, neither side idles, so that back-to-back traffic is covered too.
   bit   no_idling;
   int   rsp_stall_left;

   bbs_req_if req_chan();
   bbs_rsp_if rsp_chan();

   stack_tracker tracker = new();

   bounding_box_stack dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // The receiving side stalls for a random number of cycles after each response
   // it takes. The countdown runs whether or not a response is waiting, so the
   // stalls land on every phase of the block's work.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready)
         rsp_stall_left = no_idling ? 0 : $urandom_range(0, MAX_IDLE);
      if (rsp_stall_left > 0) begin
         rsp_stall_left = rsp_stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor: both handshakes are sampled at the rising edge, before the block's
   // registers move, so every request is seen before its response can be.
   always @(posedge clock) begin
      box_request_type  seen_req;
      box_response_type seen_rsp;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req.func   = bbs_pkg::func_type'(req_chan.func);
            seen_req.merge  = req_chan.merge_on_pop;
            seen_req.a[0]   = req_chan.a_x;
            seen_req.a[1]   = req_chan.a_y;
            seen_req.a[2]   = req_chan.a_z;
            seen_req.b[0]   = req_chan.b_x;
            seen_req.b[1]   = req_chan.b_y;
            seen_req.b[2]   = req_chan.b_z;
            seen_req.radius = req_chan.radius;
            tracker.note_request(seen_req);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.func   = bbs_pkg::FUNC_CLEAR;
            seen_rsp.serial = 0;
            seen_rsp.depth  = rsp_chan.stack_depth;
            seen_rsp.error  = rsp_chan.error;
            seen_rsp.oa[0]  = rsp_chan.out_a_x;
            seen_rsp.oa[1]  = rsp_chan.out_a_y;
            seen_rsp.oa[2]  = rsp_chan.out_a_z;
            seen_rsp.ob[0]  = rsp_chan.out_b_x;
            seen_rsp.ob[1]  = rsp_chan.out_b_y;
            seen_rsp.ob[2]  = rsp_chan.out_b_z;
            tracker.check_response(seen_rsp);
         end
      end
   end

   function automatic box_request_type make_request(bbs_pkg::func_type f, logic m,
                                                    int ax, int ay, int az,
                                                    int bx, int by, int bz, int r);
      box_request_type rq;
      rq.func   = f;
      rq.merge  = m;
      rq.a[0]   = ax;
      rq.a[1]   = ay;
      rq.a[2]   = az;
      rq.b[0]   = bx;
      rq.b[1]   = by;
      rq.b[2]   = bz;
      rq.radius = r;
      return rq;
   endfunction

   // Coordinates are often full-range, with a share of small values around the
   // origin and of values next to either end of the range, where saturation bites.
   function automatic int pick_coord();
      int mode;
      int v;
      mode = $urandom_range(0, 9);
      case (mode)
         4, 5, 6: begin
            v = $urandom_range(0, 32'h0008_0000);
            v = v - 32'sh0004_0000;
         end
         7:       v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
         8:       v = 32'sh8000_0000 + $urandom_range(0, 3);
         9:       v = $urandom_range(0, 2) - 1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic int pick_radius();
      int mode;
      int v;
      mode = $urandom_range(0, 5);
      case (mode)
         0, 1:    v = $urandom_range(0, 32'h7FFF_FFFF);
         2:       v = 32'sh7FFF_FFFF - $urandom_range(0, 3);
         3:       v = $urandom_range(0, 1);
         default: v = $urandom_range(0, 32'h0010_0000);
      endcase
      return v;
   endfunction

   // The mix of operations depends on the flavour of the block: a geometry stream
   // led by growth, a deepening one that runs into the full stack, and a
   // shallow one that keeps popping at depth one.
   function automatic bbs_pkg::func_type pick_func(int flavour);
      int roll;
      int push_weight;
      int pop_weight;
      roll = $urandom_range(0, 99);
      case (flavour)
         1:       begin push_weight = 30; pop_weight = 10; end
         2:       begin push_weight = 10; pop_weight = 30; end
         default: begin push_weight = 8;  pop_weight = 8;  end
      endcase
      if (roll < push_weight) return bbs_pkg::FUNC_PUSH;
      if (roll < push_weight + pop_weight) return bbs_pkg::FUNC_POP;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return bbs_pkg::FUNC_GROW;
         4:          return bbs_pkg::FUNC_CLEAR;
         5:          return bbs_pkg::FUNC_SET_CS;
         6:          return bbs_pkg::FUNC_SET_LH;
         7:          return bbs_pkg::FUNC_READ_LH;
         default:    return bbs_pkg::FUNC_READ_CS;
      endcase
   endfunction

   // Sends one request: an optional gap with valid low, then valid held until the
   // block takes the request. Valid is only lowered when a gap follows, so it is
   // never dropped and raised again within one time step.
   task automatic send_request(box_request_type rq);
      int gap;
      gap = no_idling ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= rq.func;
      req_chan.merge_on_pop <= rq.merge;
      req_chan.a_x          <= rq.a[0];
      req_chan.a_y          <= rq.a[1];
      req_chan.a_z          <= rq.a[2];
      req_chan.b_x          <= rq.b[0];
      req_chan.b_y          <= rq.b[1];
      req_chan.b_z          <= rq.b[2];
      req_chan.radius       <= rq.radius[30:0];
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
   endtask

   // Holds the sender back until every outstanding response has come back. The
   // first edge is always waited for, so that the monitor has noted the request
   // taken at the edge where the sender arrived.
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (tracker.pending() != 0);
   endtask

   initial begin
      int flavour;

      clock                 = 1'b0;
      reset                 = 1'b1;
      cycle_count           = 0;
      no_idling             = 1'b0;
      rsp_stall_left        = 0;
      req_chan.valid        = 1'b0;
      req_chan.func         = bbs_pkg::FUNC_CLEAR;
      req_chan.merge_on_pop = 1'b0;
      req_chan.a_x          = '0;
      req_chan.a_y          = '0;
      req_chan.a_z          = '0;
      req_chan.b_x          = '0;
      req_chan.b_y          = '0;
      req_chan.b_z          = '0;
      req_chan.radius       = '0;
      rsp_chan.ready        = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty box straight after reset is read both ways; the
      // size of an empty box saturates to the most negative value.
      send_request(make_request(bbs_pkg::FUNC_READ_LH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(bbs_pkg::FUNC_READ_CS, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      // A pop with only one box on the stack is refused.
      send_request(make_request(bbs_pkg::FUNC_POP, 1'b1, 0, 0, 0, 0, 0, 0, 0));
      // Growth by the largest sphere at the ends of the range saturates both ways.
      send_request(make_request(bbs_pkg::FUNC_GROW, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                                0, 0, 0, 32'sh7FFF_FFFF));
      // Centre and size at the extremes, with a negative size given as it is.
      send_request(make_request(bbs_pkg::FUNC_SET_CS, 1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                                32'sh8000_0000, 32'sh7FFF_FFFF, -1, 0));
      send_request(make_request(bbs_pkg::FUNC_READ_CS, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      // Low and high set the wrong way round are taken without complaint.
      send_request(make_request(bbs_pkg::FUNC_SET_LH, 1'b0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
                                32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0));
      send_request(make_request(bbs_pkg::FUNC_READ_CS, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(bbs_pkg::FUNC_CLEAR, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(bbs_pkg::FUNC_SET_LH, 1'b0, -32'sh0001_0000, -32'sh0002_0000, 5,
                                32'sh0001_0000, 32'sh0002_0000, 7, 0));
      // Fill the stack, then push once more into the full stack.
      for (int i = 1; i < bbs_pkg::STACK_DEPTH; i++)
         send_request(make_request(bbs_pkg::FUNC_PUSH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(bbs_pkg::FUNC_PUSH, 1'b0, 0, 0, 0, 0, 0, 0, 0));
      send_request(make_request(bbs_pkg::FUNC_GROW, 1'b0, 32'sh0010_0000, 0, -32'sh0010_0000,
                                0, 0, 0, 32'sh0000_8000));
      send_request(make_request(bbs_pkg::FUNC_POP, 1'b1, 0, 0, 0, 0, 0, 0, 0));
      drain_responses();

      // Random part, in blocks that each keep one flavour and idling mode. Every
      // few blocks the sender waits for the stack to catch up completely.
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         flavour   = $urandom_range(0, 2);
         no_idling = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < BLOCK_SIZE; i++)
            send_request(make_request(pick_func(flavour), $urandom_range(0, 1),
                                      pick_coord(), pick_coord(), pick_coord(),
                                      pick_coord(), pick_coord(), pick_coord(),
                                      pick_radius()));
         if (blk % 9 == 8) drain_responses();
      end
      no_idling = 1'b0;

      // Wind down: wait for the last responses, then for anything stray to show.
      drain_responses();
      repeat (4) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
